// ===== design/napt_pkg.sv =====
// Shared types and constants for the NAPT port translation table.
package napt_pkg;

  localparam int ENTRIES_DEF = 4096;
  localparam int NTAB = 3;
  localparam logic [15:0] PORT_BASE_RST = 16'd20000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic [1:0] PROTO_ICMP  = 2'd2;
  localparam logic [1:0] PROTO_UNSUP = 2'd3;

  localparam logic [2:0] RES_UNSUP   = 3'd0;
  localparam logic [2:0] RES_MISS    = 3'd1;
  localparam logic [2:0] RES_FULL    = 3'd2;
  localparam logic [2:0] RES_IN_HIT  = 3'd3;
  localparam logic [2:0] RES_OUT_HIT = 3'd4;
  localparam logic [2:0] RES_ALLOC   = 3'd5;

  localparam logic CFG_GLOBAL_IP = 1'b0;
  localparam logic CFG_PORT_BASE = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [31:0] laddr;
    logic [15:0] lport;
    logic [15:0] gport;
    logic [31:0] gaddr;
  } ent_t;

  typedef struct packed {
    logic       load;
    logic       clr_wr;
    logic       scan_rd;
    logic       in_rd;
    logic       chk_en;
    logic       alloc_wr;
    logic       res_load;
    logic [2:0] res_sel;
    logic       post;
  } cmd_t;

  typedef struct packed {
    logic unsup;
    logic incoming;
    logic off_ok;
    logic hit;
    logic found;
    logic out_busy;
  } stat_t;

endpackage

// ===== design/napt_port_translation_table_core.sv =====
// Top level of the NAPT port translation table: controller plus datapath.
// After reset a clearing pass writes every slot of the three tables before the
// first word is taken; configuration writes are taken throughout. An
// unsupported protocol answers without reading the slot memory, an incoming
// lookup with at most one read of it. An outgoing word scans its table one slot a
// cycle through the single read port: a hit ends the scan at its slot, while
// a miss reads every slot before it allocates or answers that the table is full.
// One word is worked on at a time; the result register lets a finished result
// wait on m_tready while the next word is accepted.
module napt_port_translation_table_core #(
  parameter int ENTRIES = napt_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [2:0]  s_tuser,   // func[0], proto[2:1]
  input  logic [47:0] s_tdata,   // addr[31:0], port[47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // status[1:0], allocated[2]
  output logic [47:0] m_tdata    // new_addr[31:0], new_port[47:32]
);

  localparam int ADDR_W = $clog2(napt_pkg::NTAB * ENTRIES);

  napt_pkg::cmd_t    cmd;
  napt_pkg::stat_t   stat;
  logic [ADDR_W-1:0] cnt;

  napt_ctrl #(.ENTRIES(ENTRIES), .ADDR_W(ADDR_W)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd),
    .cnt      (cnt)
  );

  napt_dpath #(.ENTRIES(ENTRIES), .ADDR_W(ADDR_W)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_user   (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .cnt       (cnt),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_user  (m_tuser),
    .out_data  (m_tdata)
  );

endmodule

// ===== design/napt_ctrl.sv =====
// Controller state machine: clearing pass, lookup, scan and allocation sequencing.
module napt_ctrl #(
  parameter int ENTRIES = napt_pkg::ENTRIES_DEF,
  parameter int ADDR_W = $clog2(napt_pkg::NTAB * ENTRIES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  napt_pkg::stat_t     stat,
  output napt_pkg::cmd_t      cmd,
  output logic [ADDR_W-1:0]   cnt
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_IN_RD  = 4'd3;
  localparam logic [3:0] S_IN_CHK = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_TAIL   = 4'd6;
  localparam logic [3:0] S_DECIDE = 4'd7;
  localparam logic [3:0] S_ALLOC  = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(napt_pkg::NTAB * ENTRIES - 1);
  localparam logic [ADDR_W-1:0] SCAN_LAST = ADDR_W'(ENTRIES - 1);

  logic [3:0]        state, state_next;
  logic [ADDR_W-1:0] cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cnt_next   = cnt + 1'b1;
        if (cnt == CLR_LAST) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cnt_next = '0;
        if (stat.unsup) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = napt_pkg::RES_UNSUP;
          state_next   = S_DONE;
        end else if (stat.incoming) begin
          if (stat.off_ok) begin
            state_next = S_IN_RD;
          end else begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = napt_pkg::RES_MISS;
            state_next   = S_DONE;
          end
        end else begin
          state_next = S_SCAN;
        end
      end
      S_IN_RD: begin
        cmd.in_rd  = 1'b1;
        state_next = S_IN_CHK;
      end
      S_IN_CHK: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = stat.hit ? napt_pkg::RES_IN_HIT : napt_pkg::RES_MISS;
        state_next   = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        cmd.chk_en  = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = napt_pkg::RES_OUT_HIT;
          state_next   = S_DONE;
        end else if (cnt == SCAN_LAST) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.chk_en = 1'b1;
        if (stat.hit) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = napt_pkg::RES_OUT_HIT;
          state_next   = S_DONE;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.found) begin
          state_next = S_ALLOC;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = napt_pkg::RES_FULL;
          state_next   = S_DONE;
        end
      end
      S_ALLOC: begin
        cmd.alloc_wr = 1'b1;
        cmd.res_load = 1'b1;
        cmd.res_sel  = napt_pkg::RES_ALLOC;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/napt_dpath.sv =====
// Datapath: slot memory, item and config registers, match logic and result stage.
module napt_dpath #(
  parameter int ENTRIES = napt_pkg::ENTRIES_DEF,
  parameter int ADDR_W = $clog2(napt_pkg::NTAB * ENTRIES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic [2:0]        in_user,
  input  logic [47:0]       in_data,
  input  napt_pkg::cmd_t    cmd,
  input  logic [ADDR_W-1:0] cnt,
  output napt_pkg::stat_t   stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_user,
  output logic [47:0]       out_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [ADDR_W-1:0] TB1 = ADDR_W'(ENTRIES);
  localparam logic [ADDR_W-1:0] TB2 = ADDR_W'(2 * ENTRIES);

  napt_pkg::ent_t mem [napt_pkg::NTAB * ENTRIES];
  napt_pkg::ent_t rd_q, wr_ent;

  logic [31:0]       global_ip;
  logic [15:0]       port_base;
  logic              func_q;
  logic [1:0]        proto_q;
  logic [31:0]       addr_q;
  logic [15:0]       port_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx;
  logic              free_found, pref_free;
  logic [IDX_W-1:0]  free_idx;
  logic [15:0]       base, off;
  logic              off_ok;
  logic [ADDR_W-1:0] tbase, raddr, waddr;
  logic [IDX_W-1:0]  pick;
  logic              hit, chk_free;
  logic [1:0]        res_st;
  logic              res_al;
  logic [31:0]       res_addr;
  logic [15:0]       res_port;

  assign base   = (proto_q == napt_pkg::PROTO_ICMP) ? 16'd0 : port_base;
  assign off    = port_q - base;
  assign off_ok = {1'b0, off} < 17'(ENTRIES);
  assign pick   = pref_free ? off[IDX_W-1:0] : free_idx;

  always_comb begin
    unique case (proto_q)
      2'd1:    tbase = TB1;
      2'd2:    tbase = TB2;
      default: tbase = '0;
    endcase
  end

  assign rd_idx = cmd.in_rd ? off[IDX_W-1:0] : cnt[IDX_W-1:0];
  assign raddr  = tbase + ADDR_W'(rd_idx);
  assign waddr  = cmd.clr_wr ? cnt : tbase + ADDR_W'(pick);

  always_comb begin
    wr_ent = '0;
    if (!cmd.clr_wr) begin
      wr_ent.valid = 1'b1;
      wr_ent.laddr = addr_q;
      wr_ent.lport = port_q;
      wr_ent.gport = base + 16'(pick);
      wr_ent.gaddr = global_ip;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr || cmd.alloc_wr) begin
      mem[waddr] <= wr_ent;
    end
    rd_q     <= mem[raddr];
    rd_idx_q <= rd_idx;
  end

  assign hit = rd_vld_q && rd_q.valid &&
               (func_q ? (rd_q.gaddr == addr_q && rd_q.gport == port_q)
                       : (rd_q.laddr == addr_q && rd_q.lport == port_q));
  assign chk_free = cmd.chk_en && rd_vld_q && !rd_q.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      global_ip <= '0;
      port_base <= napt_pkg::PORT_BASE_RST;
      rd_vld_q  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          napt_pkg::CFG_GLOBAL_IP: global_ip <= cfg_wdata;
          napt_pkg::CFG_PORT_BASE: port_base <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      rd_vld_q <= cmd.scan_rd || cmd.in_rd;
      if (cmd.post) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q     <= in_user[0];
      proto_q    <= in_user[2:1];
      addr_q     <= in_data[31:0];
      port_q     <= in_data[47:32];
      free_found <= 1'b0;
      pref_free  <= 1'b0;
    end else if (chk_free) begin
      if (!free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx_q;
      end
      if (off_ok && rd_idx_q == off[IDX_W-1:0]) begin
        pref_free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_st   <= napt_pkg::ST_OK;
      res_al   <= 1'b0;
      res_addr <= '0;
      res_port <= '0;
      unique case (cmd.res_sel)
        napt_pkg::RES_UNSUP: res_st <= napt_pkg::ST_UNSUP;
        napt_pkg::RES_MISS:  res_st <= napt_pkg::ST_MISS;
        napt_pkg::RES_FULL:  res_st <= napt_pkg::ST_FULL;
        napt_pkg::RES_IN_HIT: begin
          res_addr <= rd_q.laddr;
          res_port <= rd_q.lport;
        end
        napt_pkg::RES_OUT_HIT: begin
          res_addr <= rd_q.gaddr;
          res_port <= rd_q.gport;
        end
        napt_pkg::RES_ALLOC: begin
          res_addr <= global_ip;
          res_port <= base + 16'(pick);
          res_al   <= 1'b1;
        end
        default: res_st <= napt_pkg::ST_UNSUP;
      endcase
    end
    if (cmd.post) begin
      out_user <= {res_al, res_st};
      out_data <= {res_port, res_addr};
    end
  end

  assign stat.unsup    = (proto_q == napt_pkg::PROTO_UNSUP);
  assign stat.incoming = func_q;
  assign stat.off_ok   = off_ok;
  assign stat.hit      = hit;
  assign stat.found    = free_found || pref_free;
  assign stat.out_busy = out_valid && !out_ready;

endmodule

// ===== verif/tb_napt_port_translation_table_core.sv =====
// Testbench for the NAPT port translation table: stream stimulus, scoreboard check.
class napt_scoreboard;
  localparam int N = 4096;
  bit [31:0] gip;
  bit [15:0] pbase;
  bit        vld [3*N];
  bit [31:0] laddr [3*N];
  bit [15:0] lport [3*N];
  bit [15:0] gport [3*N];
  bit [31:0] gaddr [3*N];
  bit [50:0] pending[$];
  int        checked;
  int        allocs;
  int        fulls;

  function new();
    gip = 0;
    pbase = 16'd20000;
    foreach (vld[i]) vld[i] = 0;
  endfunction

  function void set_reg(bit idx, bit [31:0] v);
    if (idx == napt_pkg::CFG_GLOBAL_IP) gip = v;
    else pbase = v[15:0];
  endfunction

  function void note_word(bit func, bit [1:0] proto, bit [31:0] addr, bit [15:0] port);
    bit [1:0]  st;
    bit [31:0] na;
    bit [15:0] np;
    bit        al;
    bit [15:0] b;
    bit [15:0] off;
    int        t0;
    int        s;
    int        pick;
    st = napt_pkg::ST_OK;
    na = 0;
    np = 0;
    al = 0;
    pick = -1;
    if (proto == napt_pkg::PROTO_UNSUP) begin
      st = napt_pkg::ST_UNSUP;
    end else begin
      b = (proto == napt_pkg::PROTO_ICMP) ? 16'd0 : pbase;
      off = port - b;
      t0 = proto * N;
      if (func) begin
        s = t0 + off;
        if (off < N && vld[s] && gaddr[s] == addr && gport[s] == port) begin
          na = laddr[s];
          np = lport[s];
        end else begin
          st = napt_pkg::ST_MISS;
        end
      end else begin
        for (int i = 0; i < N; i++) begin
          s = t0 + i;
          if (vld[s] && laddr[s] == addr && lport[s] == port) begin
            pick = s;
            break;
          end
        end
        if (pick >= 0) begin
          na = gaddr[pick];
          np = gport[pick];
        end else begin
          if (off < N && !vld[t0 + off]) pick = off;
          else
            for (int i = 0; i < N; i++)
              if (!vld[t0 + i]) begin
                pick = i;
                break;
              end
          if (pick < 0) begin
            st = napt_pkg::ST_FULL;
            fulls++;
          end else begin
            s = t0 + pick;
            vld[s] = 1;
            laddr[s] = addr;
            lport[s] = port;
            gport[s] = b + pick[15:0];
            gaddr[s] = gip;
            na = gip;
            np = gport[s];
            al = 1;
            allocs++;
          end
        end
      end
    end
    pending.push_back({al, np, na, st});
  endfunction

  function bit check_word(bit [2:0] user, bit [47:0] data, output string msg);
    bit [50:0] e;
    msg = "";
    if (pending.size() == 0) begin
      msg = $sformatf("result with nothing pending: user=%h data=%h", user, data);
      return 0;
    end
    e = pending.pop_front();
    checked++;
    if (user[1:0] != e[1:0] || user[2] != e[50] || data[31:0] != e[33:2] ||
        data[47:32] != e[49:34]) begin
      msg = $sformatf("st %0d/%0d addr %h/%h port %0d/%0d alloc %0d/%0d",
                      user[1:0], e[1:0], data[31:0], e[33:2], data[47:32], e[49:34],
                      user[2], e[50]);
      return 0;
    end
    return 1;
  endfunction
endclass

module tb_napt_port_translation_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [2:0]  s_tuser;   // func[0], proto[2:1]
  logic [47:0] s_tdata;   // addr[31:0], port[47:32]
  logic        m_tvalid;
  logic        m_tready;
  logic [2:0]  m_tuser;   // status[1:0], allocated[2]
  logic [47:0] m_tdata;   // new_addr[31:0], new_port[47:32]

  napt_scoreboard sb;
  int  mismatches;
  int  idle_cycles;
  bit  hold_off;
  bit  done;
  bit [31:0] flow_addr[$];
  bit [15:0] flow_port[$];
  bit [1:0]  flow_proto[$];

  napt_port_translation_table_core uut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report(input string what);
    $display("MISMATCH: %s", what);
    mismatches++;
  endtask

  function automatic int gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(bit func, bit [1:0] proto, bit [31:0] addr, bit [15:0] port);
    int g;
    g = gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= {proto, func};
    s_tdata <= {port, addr};
    do @(posedge clk); while (!s_tready);
    sb.note_word(func, proto, addr, port);
    if (!func && proto != napt_pkg::PROTO_UNSUP) begin
      flow_addr.push_back(addr);
      flow_port.push_back(port);
      flow_proto.push_back(proto);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4200) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, bit [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic random_word();
    int r;
    int k;
    bit [15:0] b;
    r = $urandom_range(0, 99);
    if (r < 35 && flow_addr.size() > 0) begin
      k = $urandom_range(0, flow_addr.size() - 1);
      send_word(1'b0, flow_proto[k], flow_addr[k], flow_port[k]);
    end else if (r < 65) begin
      k = $urandom_range(0, 2);
      b = (k == 2) ? 16'd0 : sb.pbase;
      send_word(1'b1, k[1:0], ($urandom_range(0, 3) == 0) ? $urandom : sb.gip,
                16'(b + $urandom_range(0, 20)));
    end else begin
      send_word(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), $urandom,
                ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                            : 16'(sb.pbase + $urandom_range(0, 30)));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 9) < 7);
    end
  end

  always @(posedge clk) begin
    string msg;
    if (!rst && m_tvalid && m_tready) begin
      if (!sb.check_word(m_tuser, m_tdata, msg)) report(msg);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (!done && idle_cycles > 30000) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    sb = new();
    mismatches = 0;
    idle_cycles = 0;
    hold_off = 1'b0;
    done = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_wdata = '0;
    s_tvalid = 1'b0;
    s_tuser = '0;
    s_tdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_reg(napt_pkg::CFG_GLOBAL_IP, 32'hC633_6401);
    // directed
    send_word(1'b0, 2'd0, 32'h0A00_0001, 16'd20005);
    send_word(1'b0, 2'd0, 32'h0A00_0001, 16'd20005);
    send_word(1'b1, 2'd0, 32'hC633_6401, 16'd20005);
    send_word(1'b1, 2'd0, 32'h0000_0000, 16'd20005);
    send_word(1'b1, 2'd0, 32'hC633_6401, 16'd20006);
    send_word(1'b0, 2'd0, 32'h0A00_0002, 16'd80);
    send_word(1'b0, 2'd0, 32'h0A00_0003, 16'd20005);
    send_word(1'b0, 2'd1, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(1'b0, 2'd1, 32'h0000_0000, 16'd0);
    send_word(1'b0, 2'd2, 32'h0A00_0004, 16'd7);
    send_word(1'b1, 2'd2, 32'hC633_6401, 16'd7);
    send_word(1'b1, 2'd2, 32'hC633_6401, 16'hFFFF);
    send_word(1'b0, 2'd3, 32'h0A00_0005, 16'd1);
    send_word(1'b1, 2'd3, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(1'b1, 2'd1, 32'hC633_6401, 16'd19999);
    drain();
    write_reg(napt_pkg::CFG_GLOBAL_IP, 32'hFFFF_FFFF);
    write_reg(napt_pkg::CFG_PORT_BASE, 32'd65530);
    send_word(1'b0, 2'd0, 32'h0A00_0001, 16'd20005);
    send_word(1'b0, 2'd1, 32'h0A00_0009, 16'd65535);
    send_word(1'b0, 2'd1, 32'h0A00_000A, 16'd2);
    send_word(1'b1, 2'd1, 32'hFFFF_FFFF, 16'd2);
    send_word(1'b1, 2'd1, 32'hFFFF_FFFF, 16'd65535);
    // long receiver stall while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (6) send_word(1'b0, 2'd3, $urandom, 16'($urandom));
    join
    drain();
    write_reg(napt_pkg::CFG_PORT_BASE, 32'd0);
    write_reg(napt_pkg::CFG_GLOBAL_IP, 32'd0);
    repeat (38) random_word();
    drain();
    write_reg(napt_pkg::CFG_PORT_BASE, $urandom_range(1, 65534));
    write_reg(napt_pkg::CFG_GLOBAL_IP, $urandom);
    repeat (38) random_word();
    drain();
    write_reg(napt_pkg::CFG_PORT_BASE, 32'd20000);
    repeat (38) random_word();
    drain();
    done = 1'b1;
    $display("checked %0d results, %0d allocations, %0d table-full answers",
             sb.checked, sb.allocs, sb.fulls);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/napt_pkg.sv
design/napt_ctrl.sv
design/napt_dpath.sv
design/napt_port_translation_table_core.sv
verif/tb_napt_port_translation_table_core.sv
